FILE: hdl/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// Used by the front, queue, back and top level; depends on nothing.
package jse_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
	localparam int MAX_BYTES = 8;
	localparam logic [15:0] CAPACITY_RESET = 16'd4096;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	typedef enum logic [2:0] {
		CMD_RAW = 3'd0,
		CMD_STR = 3'd1,
		CMD_NULL = 3'd2,
		CMD_EMPTY = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0] last_idx;
		logic present;
		logic discard;
		logic ok;
		logic [15:0] len;
	} job_t;

endpackage

FILE: hdl/jse_front.sv
// Front part: accepts input beats, escapes them, checks capacity, builds jobs.
// Holds the capacity register and writer state; uses jse_pkg.
module jse_front import jse_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic in_valid,
	input logic [2:0] in_cmd,
	input logic [7:0] in_byte,
	input logic in_first,
	input logic in_last,
	input logic q_full,
	output logic in_ready,
	output logic push,
	output job_t push_job
);

	localparam int WB = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

	logic [LENGTH_BITS-1:0] fill_q, rs_q, fill_n, rs_n, rs_nxt;
	logic healthy_q, healthy_n;
	logic [15:0] cap_q;
	logic [WB-1:0] cap_ext, lim, eff, sum;
	logic ready_now, fits, acc, is_start;
	logic [5:0][7:0] esc;
	logic [2:0] esc_n;
	logic [MAX_BYTES-1:0][7:0] sbuf;
	logic [3:0] n;
	logic [2:0] j;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
	endfunction

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign push = acc;

	always_comb begin
		esc = '0;
		esc_n = 3'd2;
		esc[0] = CH_BSLASH;
		unique case (in_byte)
			8'h22: esc[1] = CH_QUOTE;
			8'h5c: esc[1] = CH_BSLASH;
			8'h08: esc[1] = 8'h62;
			8'h0c: esc[1] = 8'h66;
			8'h0a: esc[1] = 8'h6e;
			8'h0d: esc[1] = 8'h72;
			8'h09: esc[1] = 8'h74;
			default: begin
				if (in_byte < 8'h20) begin
					esc[1] = 8'h75;
					esc[2] = 8'h30;
					esc[3] = 8'h30;
					esc[4] = hex_digit(in_byte[7:4]);
					esc[5] = hex_digit(in_byte[3:0]);
					esc_n = 3'd6;
				end else begin
					esc[0] = in_byte;
					esc_n = 3'd1;
				end
			end
		endcase
	end

	always_comb begin
		sbuf = '0;
		j = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			j = 3'(i - (in_first ? 1 : 0));
			if (in_first && i == 0) begin
				sbuf[i] = CH_QUOTE;
			end else if (j < esc_n) begin
				sbuf[i] = esc[j];
			end else begin
				sbuf[i] = CH_QUOTE;
			end
		end
	end

	always_comb begin
		cap_ext = WB'(cap_q);
		lim = WB'(1) << LENGTH_BITS;
		eff = (cap_ext < lim) ? cap_ext : lim;
		ready_now = healthy_q && (cap_q != 16'd0) && (WB'(fill_q) < eff);

		push_job = '0;
		n = 4'd1;
		is_start = 1'b0;
		unique case (in_cmd)
			CMD_RAW: begin
				push_job.bytes[0] = in_byte;
				is_start = in_first;
			end
			CMD_STR: begin
				push_job.bytes = sbuf;
				n = 4'(in_first) + 4'(esc_n) + 4'(in_last);
				is_start = in_first;
			end
			CMD_NULL: begin
				push_job.bytes[0] = 8'h6e;
				push_job.bytes[1] = 8'h75;
				push_job.bytes[2] = 8'h6c;
				push_job.bytes[3] = 8'h6c;
				n = 4'd4;
				is_start = 1'b1;
			end
			CMD_EMPTY: begin
				push_job.bytes[0] = CH_QUOTE;
				push_job.bytes[1] = CH_QUOTE;
				n = 4'd2;
				is_start = 1'b1;
			end
			default: ;
		endcase

		rs_nxt = is_start ? fill_q : rs_q;
		sum = WB'(fill_q) + WB'(n);
		fits = ready_now && (sum < eff);

		fill_n = fill_q;
		rs_n = rs_nxt;
		healthy_n = healthy_q;
		unique case (in_cmd)
			CMD_RAW, CMD_STR, CMD_NULL, CMD_EMPTY: begin
				if (fits) begin
					fill_n = fill_q + LENGTH_BITS'(n);
					push_job.present = 1'b1;
					push_job.ok = 1'b1;
					push_job.last_idx = 3'(n - 4'd1);
					push_job.len = 16'(fill_q);
				end else begin
					healthy_n = 1'b0;
					fill_n = rs_nxt;
					push_job.discard = 1'b1;
					push_job.len = 16'(rs_nxt);
				end
			end
			CMD_RESTART: begin
				fill_n = '0;
				rs_n = '0;
				healthy_n = (cap_q != 16'd0);
				push_job.ok = (cap_q != 16'd0);
			end
			default: begin
				push_job.ok = ready_now;
				push_job.len = 16'(fill_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rs_q <= '0;
			healthy_q <= 1'b1;
			cap_q <= CAPACITY_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc) begin
				fill_q <= fill_n;
				rs_q <= rs_n;
				healthy_q <= healthy_n;
			end
		end
	end

endmodule

FILE: hdl/jse_queue.sv
// Job queue between front and back parts.
// Small register FIFO of job_t entries; uses jse_pkg.
module jse_queue import jse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_BITS-1:0] wr_q, rd_q;
	logic [QUEUE_IDX_BITS:0] cnt_q;

	assign full = (cnt_q == (QUEUE_IDX_BITS+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 :
					wr_q + QUEUE_IDX_BITS'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 :
					rd_q + QUEUE_IDX_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QUEUE_IDX_BITS+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QUEUE_IDX_BITS+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/jse_back.sv
// Back part: walks the head job one output byte per cycle into an output register while the output is not stalled.
// Pops the queue after the last beat of a job; uses jse_pkg.
module jse_back import jse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input job_t head_job,
	input logic out_ready,
	output logic pop,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic out_present,
	output logic out_end,
	output logic out_discard,
	output logic out_ok,
	output logic [15:0] out_len
);

	logic [2:0] k_q;
	logic adv, at_last;

	assign adv = head_valid && (!out_valid || out_ready);
	assign at_last = (k_q == head_job.last_idx);
	assign pop = adv && at_last;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte <= head_job.present ? head_job.bytes[k_q] : 8'd0;
			out_present <= head_job.present;
			out_end <= at_last;
			out_discard <= head_job.discard;
			out_ok <= head_job.ok;
			out_len <= head_job.present ? (head_job.len + 16'(k_q) + 16'd1) : head_job.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			k_q <= '0;
		end else begin
			if (adv) begin
				out_valid <= 1'b1;
				k_q <= at_last ? '0 : k_q + 3'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/json_string_escaper_top.sv
// Top level of the JSON string escaper: front, job queue and back.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
// channel  dir  tdata                                         tuser / tlast
// s_*      in   [7:0] data_byte                               tuser [2:0] command, [3] first_of_run; tlast last_of_run
// m_*      out  [7:0] out_byte, [8] writer_ok, [24:9] length   tuser [0] byte_present, [1] discard_run; tlast run_end
// cfg_*    in   cfg_wdata = capacity                           cfg_we write strobe
//
// One result beat per cycle while m_tready is high; an item yields 1 to 8 beats.
// The back part's one-byte-per-cycle emission sets the sustained rate.
// The front accepts a beat every cycle while the four-entry job queue has room.
// A stalled m_tready fills the queue and then drops s_tready; reset empties it.
module json_string_escaper_top import jse_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] data_byte
	input logic [3:0] s_tuser, // [2:0] command, [3] first_of_run
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // [7:0] out_byte, [8] writer_ok, [24:9] written_length
	output logic [1:0] m_tuser, // [0] byte_present, [1] discard_run
	output logic m_tlast
);

	logic push, pop, q_full, head_valid;
	job_t push_job, head_job;
	logic [7:0] out_byte;
	logic out_present, out_discard, out_ok;
	logic [15:0] out_len;

	jse_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_tvalid),
		.in_cmd(s_tuser[2:0]),
		.in_byte(s_tdata),
		.in_first(s_tuser[3]),
		.in_last(s_tlast),
		.q_full(q_full),
		.in_ready(s_tready),
		.push(push),
		.push_job(push_job)
	);

	jse_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head_job(head_job)
	);

	jse_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_job(head_job),
		.out_ready(m_tready),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_byte(out_byte),
		.out_present(out_present),
		.out_end(m_tlast),
		.out_discard(out_discard),
		.out_ok(out_ok),
		.out_len(out_len)
	);

	assign m_tdata = {7'd0, out_len, out_ok, out_byte};
	assign m_tuser = {out_discard, out_present};

endmodule

FILE: hdl/jse_checker.sv
// Port-level checks for the JSON string escaper, bound to the top level.
// Depends only on the top-level ports.
module jse_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_discard_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tlast)
		else $error("discard beat carries a byte or is not last");

	a_discard_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tdata[8])
		else $error("discard beat reports writer ok");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[8] && m_tdata[24:9] != 16'd0)
		else $error("byte beat with writer not ok or zero length");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
